>>> design/cosine_curve_smoother_core_assert.svh
// ----------------------------------------------------------------------------
// Cosine curve smoother assertion macros
// Property checks for the smoother core, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef COSINE_CURVE_SMOOTHER_CORE_ASSERT_SVH
`define COSINE_CURVE_SMOOTHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CCS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cosine curve smoother: property failed");
`define CCS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cosine curve smoother: property failed");
`else
`define CCS_ASSERT_IMP(name, ante, cons)
`define CCS_ASSERT_NXT(name, ante, cons)
`endif
`endif

>>> design/ccs_pkg.sv
// ----------------------------------------------------------------------------
// Cosine curve smoother package
// Word types and the quarter-wave cosine table in Q1.15.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int CosTableSize = 256;
    localparam longint unsigned PiQ30 = 64'd3373259426;
    localparam longint unsigned OneQ30 = 64'd1073741824;
    localparam int ThetaShift = $clog2(2 * CosTableSize);

    // rounded-up 2^64 reciprocals of the Taylor denominators (2n-1)*(2n)
    localparam logic [127:0] Two64 = 128'd1 << 64;
    localparam logic [8:1][127:0] TaylorRecip = {
        (Two64 + 128'd239) / 128'd240,
        (Two64 + 128'd181) / 128'd182,
        (Two64 + 128'd131) / 128'd132,
        (Two64 + 128'd89) / 128'd90,
        (Two64 + 128'd55) / 128'd56,
        (Two64 + 128'd29) / 128'd30,
        (Two64 + 128'd11) / 128'd12,
        (Two64 + 128'd1) / 128'd2
    };

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               last_point;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               run_end;
    } out_word_t;

    typedef logic [CosTableSize:0][15:0] cos_tab_t;

    function automatic cos_tab_t build_cos_tab();
        cos_tab_t tab;
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned q;
        longint sum;
        logic [127:0] prod;
        tab = '0;
        for (int k = 0; k <= CosTableSize; k++)
        begin
            theta = (longint'(k) * PiQ30) >> ThetaShift;
            x2 = (theta * theta) >> 30;
            t = OneQ30;
            sum = longint'(OneQ30);
            for (int n = 1; n <= 8; n++)
            begin
                prod = 128'((t * x2) >> 30) * TaylorRecip[n];
                t = prod[127:64];
                if ((n & 1) == 1)
                    sum = sum - longint'(t);
                else
                    sum = sum + longint'(t);
            end
            if (sum < 0)
                sum = 0;
            q = (longint'(sum) + 64'd16384) >> 15;
            if (q > 64'd32767)
                q = 64'd32767;
            tab[k] = q[15:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t CosTab = build_cos_tab();

endpackage

>>> design/cosine_curve_smoother_core.sv
// ----------------------------------------------------------------------------
// Cosine curve smoother core
// Expands polyline vertices into cosine-interpolated curve points.
// ----------------------------------------------------------------------------
// A vertex that finds no held vertex yields no word. A
// vertex that closes a segment runs three passes of one shared 33-step
// restoring divider (segment count, x step, phase step), then each interior
// point goes through the step, multiply and sum states, and its word may
// wait under out_stall. The input is stalled until the last word of the item
// has been taken.
module cosine_curve_smoother_core #(
    parameter int MAX_SAMPLES = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [30:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  ccs_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output ccs_pkg::out_word_t  out_word
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int HW = $clog2(2 * ccs_pkg::CosTableSize + 1);
    localparam int TW = $clog2(ccs_pkg::CosTableSize + 1);
    localparam int DivSteps = 33;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_OUT, S_MUL, S_SUM} state_t;
    typedef enum logic [1:0] {OP_CNT, OP_DX, OP_H} div_op_t;

    state_t              state_reg;
    div_op_t             op_reg;
    logic [5:0]          div_cnt_reg;
    logic [32:0]         div_q_reg;
    logic [30:0]         div_rem_reg;
    logic [30:0]         div_d_reg;
    logic [30:0]         sw_reg;
    logic                have_prev_reg;
    logic                last_reg;
    logic                final_done_reg;
    logic [31:0]         prev_x_reg;
    logic [31:0]         prev_y_reg;
    logic [31:0]         x1_reg;
    logic [31:0]         y1_reg;
    logic                d_neg_reg;
    logic [32:0]         ad_reg;
    logic signed [32:0]  s_reg;
    logic signed [32:0]  e_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       j_reg;
    logic [32:0]         qstep_reg;
    logic [CW-1:0]       rstep_reg;
    logic [HW-1:0]       hstep_reg;
    logic [CW:0]         hrstep_reg;
    logic [32:0]         qacc_reg;
    logic [CW-1:0]       racc_reg;
    logic [HW-1:0]       h_reg;
    logic [CW:0]         hrem_reg;
    logic signed [49:0]  prod_reg;
    logic [31:0]         ox_reg;
    ccs_pkg::out_word_t  out_word_reg;

    logic [31:0]         trial;
    logic                trial_ge;
    logic [30:0]         div_rem_next;
    logic [32:0]         div_q_next;
    logic [CW-1:0]       count_next;
    logic signed [32:0]  d_in;
    logic [32:0]         ad_in;
    logic [CW:0]         rsum;
    logic [CW+1:0]       hsum;
    logic [CW:0]         count2;
    logic [TW-1:0]       tab_idx;
    logic signed [16:0]  cos_val;
    logic [33:0]         x_off;
    logic [33:0]         ox_full;
    logic signed [50:0]  ysum;
    logic                more_points;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_word  = out_word_reg;

    // shared restoring divider step
    assign trial        = {div_rem_reg, div_q_reg[32]};
    assign trial_ge     = (trial >= {1'b0, div_d_reg});
    assign div_rem_next = trial_ge ? 31'(trial - {1'b0, div_d_reg}) : trial[30:0];
    assign div_q_next   = {div_q_reg[31:0], trial_ge};

    always_comb
    begin
        if (div_q_reg > 33'(MAX_SAMPLES))
            count_next = CW'(MAX_SAMPLES);
        else if (div_q_reg == '0)
            count_next = CW'(1);
        else
            count_next = div_q_reg[CW-1:0];
    end

    assign d_in  = {in_word.point_x[31], in_word.point_x} - {prev_x_reg[31], prev_x_reg};
    assign ad_in = d_in[32] ? 33'(-d_in) : 33'(d_in);

    assign rsum   = {1'b0, racc_reg} + {1'b0, rstep_reg};
    assign hsum   = {1'b0, hrem_reg} + {1'b0, hrstep_reg};
    assign count2 = {count_reg, 1'b0};
    assign more_points = (({1'b0, j_reg} + (CW+1)'(1)) < {1'b0, count_reg});

    always_comb
    begin
        if (h_reg <= HW'(ccs_pkg::CosTableSize))
        begin
            tab_idx = h_reg[TW-1:0];
            cos_val = $signed({1'b0, ccs_pkg::CosTab[tab_idx]});
        end
        else
        begin
            tab_idx = TW'(HW'(2 * ccs_pkg::CosTableSize) - h_reg);
            cos_val = -$signed({1'b0, ccs_pkg::CosTab[tab_idx]});
        end
    end

    assign x_off   = d_neg_reg ? 34'(-{1'b0, qacc_reg}) : {1'b0, qacc_reg};
    assign ox_full = {{2{prev_x_reg[31]}}, prev_x_reg} + x_off;
    assign ysum    = ({{18{s_reg[32]}}, s_reg} <<< 15) + {prod_reg[49], prod_reg}
                     + 51'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_CNT;
            div_cnt_reg    <= '0;
            div_q_reg      <= '0;
            div_rem_reg    <= '0;
            div_d_reg      <= '0;
            sw_reg         <= 31'd65536;
            have_prev_reg  <= 1'b0;
            last_reg       <= 1'b0;
            final_done_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            x1_reg         <= '0;
            y1_reg         <= '0;
            d_neg_reg      <= 1'b0;
            ad_reg         <= '0;
            s_reg          <= '0;
            e_reg          <= '0;
            count_reg      <= '0;
            j_reg          <= '0;
            qstep_reg      <= '0;
            rstep_reg      <= '0;
            hstep_reg      <= '0;
            hrstep_reg     <= '0;
            qacc_reg       <= '0;
            racc_reg       <= '0;
            h_reg          <= '0;
            hrem_reg       <= '0;
            prod_reg       <= '0;
            ox_reg         <= '0;
            out_word_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                sw_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (!have_prev_reg)
                        begin
                            if (!in_word.last_point)
                            begin
                                prev_x_reg    <= in_word.point_x;
                                prev_y_reg    <= in_word.point_y;
                                have_prev_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            x1_reg      <= in_word.point_x;
                            y1_reg      <= in_word.point_y;
                            last_reg    <= in_word.last_point;
                            d_neg_reg   <= d_in[32];
                            ad_reg      <= ad_in;
                            s_reg       <= {prev_y_reg[31], prev_y_reg}
                                           + {in_word.point_y[31], in_word.point_y};
                            e_reg       <= {prev_y_reg[31], prev_y_reg}
                                           - {in_word.point_y[31], in_word.point_y};
                            op_reg      <= OP_CNT;
                            div_q_reg   <= ad_in;
                            div_rem_reg <= '0;
                            div_d_reg   <= (sw_reg == '0) ? 31'd1 : sw_reg;
                            div_cnt_reg <= 6'(DivSteps);
                            state_reg   <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg != '0)
                    begin
                        div_q_reg   <= div_q_next;
                        div_rem_reg <= div_rem_next;
                        div_cnt_reg <= div_cnt_reg - 6'd1;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_CNT:
                            begin
                                count_reg   <= count_next;
                                op_reg      <= OP_DX;
                                div_q_reg   <= ad_reg;
                                div_rem_reg <= '0;
                                div_d_reg   <= 31'(count_next);
                                div_cnt_reg <= 6'(DivSteps);
                            end
                            OP_DX:
                            begin
                                qstep_reg   <= div_q_reg;
                                rstep_reg   <= div_rem_reg[CW-1:0];
                                op_reg      <= OP_H;
                                div_q_reg   <= 33'(4 * ccs_pkg::CosTableSize);
                                div_rem_reg <= '0;
                                div_d_reg   <= 31'(count2);
                                div_cnt_reg <= 6'(DivSteps);
                            end
                            default:
                            begin
                                hstep_reg      <= div_q_reg[HW-1:0];
                                hrstep_reg     <= div_rem_reg[CW:0];
                                j_reg          <= '0;
                                qacc_reg       <= '0;
                                racc_reg       <= '0;
                                h_reg          <= '0;
                                hrem_reg       <= {1'b0, count_reg};
                                final_done_reg <= 1'b0;
                                out_word_reg   <= {prev_x_reg, prev_y_reg,
                                                   (count_reg == CW'(1)) && !last_reg};
                                state_reg      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (more_points)
                        begin
                            j_reg <= j_reg + CW'(1);
                            if (rsum >= {1'b0, count_reg})
                            begin
                                racc_reg <= CW'(rsum - {1'b0, count_reg});
                                qacc_reg <= qacc_reg + qstep_reg + 33'd1;
                            end
                            else
                            begin
                                racc_reg <= rsum[CW-1:0];
                                qacc_reg <= qacc_reg + qstep_reg;
                            end
                            if (hsum >= {1'b0, count2})
                            begin
                                hrem_reg <= (CW+1)'(hsum - {1'b0, count2});
                                h_reg    <= h_reg + hstep_reg + HW'(1);
                            end
                            else
                            begin
                                hrem_reg <= hsum[CW:0];
                                h_reg    <= h_reg + hstep_reg;
                            end
                            state_reg <= S_MUL;
                        end
                        else if (last_reg && !final_done_reg)
                        begin
                            out_word_reg   <= {x1_reg, y1_reg, 1'b1};
                            final_done_reg <= 1'b1;
                        end
                        else
                        begin
                            if (last_reg)
                            begin
                                prev_x_reg    <= '0;
                                prev_y_reg    <= '0;
                                have_prev_reg <= 1'b0;
                            end
                            else
                            begin
                                prev_x_reg <= x1_reg;
                                prev_y_reg <= y1_reg;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= e_reg * cos_val;
                    ox_reg    <= ox_full[31:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    out_word_reg <= {ox_reg, ysum[47:16],
                                     (({1'b0, j_reg} + (CW+1)'(1)) == {1'b0, count_reg})
                                     && !last_reg};
                    state_reg    <= S_OUT;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "cosine_curve_smoother_core_assert.svh"

    `CCS_ASSERT_IMP(a_busy_while_out, out_valid, in_stall)
    `CCS_ASSERT_IMP(a_interior_count, state_reg == S_MUL, count_reg > CW'(1))
    `CCS_ASSERT_IMP(a_phase_range, state_reg == S_MUL, h_reg <= HW'(2 * ccs_pkg::CosTableSize))
    `CCS_ASSERT_NXT(a_end_to_idle, out_valid && !out_stall && out_word.run_end, state_reg == S_IDLE)

endmodule

>>> test/tb_cosine_curve_smoother_core.sv
// ----------------------------------------------------------------------------
// Cosine curve smoother core testbench
// Drives polylines through the core under varied idle and stall patterns,
// predicts every curve point in a scoreboard and compares words in order.
// ----------------------------------------------------------------------------
module tb_cosine_curve_smoother_core;

    localparam int MaxSamples = 63;
    localparam int TabSize = 256;
    localparam int WatchLimit = 20000;

    class curve_scoreboard;
        logic [15:0] cos_q15 [0:TabSize];
        logic [30:0] spacing;
        logic signed [31:0] held_x;
        logic signed [31:0] held_y;
        bit held;
        ccs_pkg::out_word_t pending [$];
        int errors;

        function void build_cos();
            longint unsigned theta, x2, t, q;
            longint sum;
            for (int k = 0; k <= TabSize; k++)
            begin
                theta = (longint'(k) * 64'd3373259426) / (2 * TabSize);
                x2 = (theta * theta) >> 30;
                t = 64'd1073741824;
                sum = 64'd1073741824;
                for (int n = 1; n <= 8; n++)
                begin
                    t = ((t * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                        sum = sum - longint'(t);
                    else
                        sum = sum + longint'(t);
                end
                if (sum < 0)
                    sum = 0;
                q = (longint'(sum) + 64'd16384) >> 15;
                if (q > 64'd32767)
                    q = 64'd32767;
                cos_q15[k] = q[15:0];
            end
        endfunction

        function void clear();
            spacing = 31'd65536;
            held_x = '0;
            held_y = '0;
            held = 0;
            pending.delete();
            errors = 0;
            build_cos();
        endfunction

        function void push_point(longint x, longint y);
            ccs_pkg::out_word_t w;
            w.out_x = x[31:0];
            w.out_y = y[31:0];
            w.run_end = 1'b0;
            pending.insert(pending.size(), w);
        endfunction

        function void note_vertex(ccs_pkg::in_word_t v);
            longint x0, y0, d, s, e, ad, sw, cnt, ox, h, c, acc, oy;
            ccs_pkg::out_word_t w;
            if (!held)
            begin
                if (!v.last_point)
                begin
                    held_x = v.point_x;
                    held_y = v.point_y;
                    held = 1;
                end
                return;
            end
            x0 = held_x;
            y0 = held_y;
            d = longint'(v.point_x) - x0;
            s = y0 + longint'(v.point_y);
            e = y0 - longint'(v.point_y);
            ad = d < 0 ? -d : d;
            sw = spacing == 0 ? 1 : longint'(spacing);
            cnt = ad / sw;
            if (cnt > MaxSamples)
                cnt = MaxSamples;
            if (cnt < 1)
                cnt = 1;
            push_point(x0, y0);
            for (longint j = 1; j < cnt; j++)
            begin
                ox = x0 + (d * j) / cnt;
                h = (j * 4 * TabSize + cnt) / (2 * cnt);
                c = h <= TabSize ? longint'(cos_q15[h]) : -longint'(cos_q15[2 * TabSize - h]);
                acc = s * 32768 + e * c + 32768;
                oy = acc >>> 16;
                push_point(ox, oy);
            end
            if (v.last_point)
            begin
                push_point(v.point_x, v.point_y);
                held = 0;
                held_x = '0;
                held_y = '0;
            end
            else
            begin
                held_x = v.point_x;
                held_y = v.point_y;
            end
            w = pending.pop_back();
            w.run_end = 1'b1;
            pending.insert(pending.size(), w);
        endfunction

        task report(string what, longint got, longint want);
            $display("error: %s got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check_word(ccs_pkg::out_word_t w);
            ccs_pkg::out_word_t ex;
            if (pending.size() == 0)
            begin
                report("unexpected word x", w.out_x, 0);
                return;
            end
            ex = pending.pop_front();
            if (w.out_x !== ex.out_x)
                report("out_x", w.out_x, ex.out_x);
            if (w.out_y !== ex.out_y)
                report("out_y", w.out_y, ex.out_y);
            if (w.run_end !== ex.run_end)
                report("run_end", w.run_end, ex.run_end);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [30:0] cfg_wdata = '0;
    logic in_valid = 0;
    logic in_stall;
    ccs_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 0;
    ccs_pkg::out_word_t out_word;

    curve_scoreboard board;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int quiet = 0;

    always #4 clk = ~clk;

    cosine_curve_smoother_core #(.MAX_SAMPLES(MaxSamples)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    // receiver: random stall, with an optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(out_word);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WatchLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold valid after the accept; the next call or drain replaces it
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic lp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{point_x: x, point_y: y, last_point: lp};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_vertex('{point_x: x, point_y: y, last_point: lp});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_spacing(logic [30:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.spacing = v;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(16);
            2: return 32'h8000_0000 ^ ($urandom & 32'h0003_ffff);
            default: return $urandom_range(32'h000f_ffff) - 32'h0008_0000;
        endcase
    endfunction

    // well-formed polyline with small x steps relative to the spacing
    task automatic send_polyline(int n);
        logic signed [31:0] x, y;
        x = rand_word();
        y = rand_word();
        for (int i = 0; i < n; i++)
        begin
            send_vertex(x, y, i == n - 1);
            if ($urandom_range(7) == 0)
                x = rand_word();
            else
                x = x + $signed(32'($urandom_range(80 * 65536)) - 32'(40 * 65536));
            y = ($urandom_range(3) == 0) ? rand_word() : y + $signed($urandom >>> 12);
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_vertex(rand_word(), rand_word(), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                int n;
                n = $urandom_range(2, 6);
                send_polyline(n);
                sent += n;
            end
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone vertex, extremes, zero-width segment
        send_vertex(32'sh1234_5678, 32'sh0000_1000, 1'b1);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
        send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_vertex(32'sh0003_8000, 32'sh0010_0000, 1'b0);
        send_vertex(32'shfffd_0000, 32'shfff0_0000, 1'b0);
        send_vertex(32'shfffd_ffff, 32'shffff_ffff, 1'b1);
        drain();
        write_spacing(31'd0);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_vertex(32'sh0000_0005, 32'sh4000_0000, 1'b0);
        send_vertex(32'sh0000_0100, 32'shc000_0000, 1'b1);
        drain();
        write_spacing(31'h7fff_ffff);
        send_vertex(32'sh8000_0000, 32'sh1111_0000, 1'b0);
        send_vertex(32'sh7fff_ffff, 32'sh2222_0000, 1'b1);
        drain();
        write_spacing(31'd65536);

        // long receiver hold-off while the sender keeps offering
        hold_off = 600;
        send_polyline(6);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(100);
        drain();
        write_spacing(31'd32768);
        send_idle_pct = 72;
        random_phase(100);
        drain();
        write_spacing(31'd1);
        send_idle_pct = 0;
        recv_stall_pct = 72;
        random_phase(90);
        drain();
        write_spacing(31'd200000);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        random_phase(90);
        drain();
        write_spacing(31'($urandom) | 31'h4000_0000);
        send_idle_pct = 10;
        recv_stall_pct = 10;
        random_phase(60);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
